// File: design/e2q_pkg.sv
`default_nettype none
package e2q_pkg;
  localparam int TRIG_STAGES   = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int ANG_W   = 20;
  localparam int OUT_W   = 16;
  localparam int ORD_W   = 3;
  localparam int TURN_UNITS = 23040;
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int HW = 31;
  localparam int PW = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [HW-1:0] QUARTER_TURN = 31'd1073741824;
  localparam int OUT_MAX = 32767;

  typedef enum logic [ORD_W-1:0] {
    ORD_XYZ = 3'd0, ORD_XZY = 3'd1, ORD_YXZ = 3'd2,
    ORD_YZX = 3'd3, ORD_ZXY = 3'd4, ORD_ZYX = 3'd5,
    ORD_ID6 = 3'd6, ORD_ID7 = 3'd7
  } order_t;

  typedef logic signed [CW-1:0] comp_t;
  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 33'sd536870912;  1: r = 33'sd316933406;  2: r = 33'sd167458907;
      3: r = 33'sd85004756;   4: r = 33'sd42667331;   5: r = 33'sd21354465;
      6: r = 33'sd10679838;   7: r = 33'sd5340245;    8: r = 33'sd2670163;
      9: r = 33'sd1335087;    10: r = 33'sd667544;    11: r = 33'sd333772;
      12: r = 33'sd166886;    13: r = 33'sd83443;     14: r = 33'sd41722;
      15: r = 33'sd20861;     16: r = 33'sd10430;     17: r = 33'sd5215;
      18: r = 33'sd2608;      19: r = 33'sd1304;      20: r = 33'sd652;
      21: r = 33'sd326;       22: r = 33'sd163;       default: r = 33'sd81;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: design/euler_to_quaternion.sv
`default_nettype none
// Euler angles to quaternion. One transfer per cycle: start is taken whenever
// busy is low, and busy is always low. Each item's result appears on the quat
// ports with done high after its transfer has passed through angle reduction,
// the CORDIC chain, the two registered quaternion products and the output
// register; the receiver cannot stall, so results must be taken when done is
// high.
module euler_to_quaternion (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [e2q_pkg::ANG_W-1:0]    angle_x,
  input  wire logic signed [e2q_pkg::ANG_W-1:0]    angle_y,
  input  wire logic signed [e2q_pkg::ANG_W-1:0]    angle_z,
  input  wire logic [e2q_pkg::ORD_W-1:0]           rotation_order,
  output logic                                     done,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_w,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_x,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_y,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_z
);
  import e2q_pkg::*;

  localparam int TRIG_LAT = TRIG_STAGES + 3;
  localparam int LATENCY  = TRIG_LAT + 5;
  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam longint RND = (SH > 0) ? (64'sd1 <<< (SH - 1)) : 64'sd0;
  localparam longint ONE_OUT = 64'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [OUT_W-1:0] IDENT_W =
    OUT_W'((ONE_OUT > OUT_MAX) ? longint'(OUT_MAX) : ONE_OUT);

  logic [LATENCY-1:0] vld;
  order_t ord_pipe [TRIG_LAT+4];
  logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
  quat_t qx, qy, qz, qa, qb, qc, p1, p2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LATENCY-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    ord_pipe[0] <= order_t'(rotation_order);
    for (int i = 1; i < TRIG_LAT + 4; i++) ord_pipe[i] <= ord_pipe[i-1];
  end

  e2q_trig u_trx (.clk, .rst, .in_valid(start), .angle(angle_x), .cos_h(cx), .sin_h(sx));
  e2q_trig u_try (.clk, .rst, .in_valid(start), .angle(angle_y), .cos_h(cy), .sin_h(sy));
  e2q_trig u_trz (.clk, .rst, .in_valid(start), .angle(angle_z), .cos_h(cz), .sin_h(sz));

  assign qx = '{w: cx, x: sx, y: '0, z: '0};
  assign qy = '{w: cy, x: '0, y: sy, z: '0};
  assign qz = '{w: cz, x: '0, y: '0, z: sz};

  always_comb begin
    case (ord_pipe[TRIG_LAT-1])
      ORD_XYZ: begin qa = qz; qb = qy; qc = qx; end
      ORD_XZY: begin qa = qy; qb = qz; qc = qx; end
      ORD_YXZ: begin qa = qz; qb = qx; qc = qy; end
      ORD_YZX: begin qa = qx; qb = qz; qc = qy; end
      ORD_ZXY: begin qa = qy; qb = qx; qc = qz; end
      default: begin qa = qx; qb = qy; qc = qz; end
    endcase
  end

  quat_t qc_d1, qc_d2;
  always_ff @(posedge clk) begin
    qc_d1 <= qc;
    qc_d2 <= qc_d1;
  end

  e2q_qmul u_m1 (.clk, .a(qa), .b(qb), .r(p1));
  e2q_qmul u_m2 (.clk, .a(p1), .b(qc_d2), .r(p2));

  function automatic logic signed [OUT_W-1:0] to_out(input comp_t v);
    logic signed [CW-1:0] t;
    t = (v + CW'(RND)) >>> SH;
    if (t > OUT_MAX)       return OUT_W'(OUT_MAX);
    else if (t < -OUT_MAX) return OUT_W'(-OUT_MAX);
    else                   return OUT_W'(t);
  endfunction

  logic ident;
  assign ident = (ord_pipe[TRIG_LAT+3] == ORD_ID6) || (ord_pipe[TRIG_LAT+3] == ORD_ID7);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[LATENCY-2];
    if (ident) begin
      quat_w <= IDENT_W;
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
    end else begin
      quat_w <= to_out(p2.w);
      quat_x <= to_out(p2.x);
      quat_y <= to_out(p2.y);
      quat_z <= to_out(p2.z);
    end
  end

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> vld[LATENCY-1])
    else $error("done without matching transfer");
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_w != -16'sd32768) && (quat_x != -16'sd32768))
    else $error("output out of range");
endmodule
`default_nettype wire

// File: design/e2q_trig.sv
`default_nettype none
module e2q_trig (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire logic signed [e2q_pkg::ANG_W-1:0]     angle,
  output logic signed [e2q_pkg::CW-1:0]             cos_h,
  output logic signed [e2q_pkg::CW-1:0]             sin_h
);
  import e2q_pkg::*;

  localparam int RED_W = 15;
  localparam int QW = 6;
  localparam int RW = ANG_W + 2;
  localparam int RCP_W = 38;
  localparam int RCP_SH = 21;
  localparam logic signed [RW-1:0] TURN_R = RW'(TURN_UNITS);
  // h = floor(a*2^32/46080) = floor(a*2^22/45) = floor(a*M/2^21), M = ceil(2^43/45),
  // exact for every a below one turn
  localparam logic [RCP_W-1:0] RECIP = 38'd195468733827;

  logic signed [QW-1:0]    q;
  logic signed [QW-1:0]    q_r;
  logic signed [ANG_W-1:0] ang_r;
  logic [RED_W-1:0]        red;
  logic [RED_W-1:0]        red_q;
  logic [RCP_W+RED_W-1:0]  prod;
  logic [HW-1:0]           h;

  logic signed [CW-1:0] xs [TRIG_STAGES+1];
  logic signed [CW-1:0] ys [TRIG_STAGES+1];
  logic signed [ZW-1:0] zs [TRIG_STAGES+1];

  // Stage 1: estimate the turn count (|angle| < 23 turns), may be off by one
  always_comb begin
    logic signed [ANG_W+17:0] qp;
    qp = (ANG_W+18)'(angle) * 38'sd46603;
    q = QW'(qp >>> 30);
  end

  always_ff @(posedge clk) begin
    q_r   <= q;
    ang_r <= angle;
  end

  // Stage 2: fold the angle into one turn, fix the estimate by one step
  always_comb begin
    logic signed [RW-1:0] r;
    r = RW'(ang_r) - RW'(q_r) * TURN_R;
    if (r < 0) r = r + TURN_R;
    else if (r >= TURN_R) r = r - TURN_R;
    red = RED_W'(r);
  end

  always_ff @(posedge clk) red_q <= red;

  assign prod = (RCP_W+RED_W)'(red_q) * (RCP_W+RED_W)'(RECIP);
  always_ff @(posedge clk) h <= HW'(prod >> RCP_SH);

  assign xs[0] = (h >= QUARTER_TURN) ? '0 : CORDIC_GAIN;
  assign ys[0] = (h >= QUARTER_TURN) ? CORDIC_GAIN : '0;
  assign zs[0] = (h >= QUARTER_TURN) ? ZW'(h - QUARTER_TURN) : ZW'(h);

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yr;
    logic signed [ZW-1:0] zr;
    always_ff @(posedge clk) begin
      if (zs[i] >= 0) begin
        xr <= xs[i] - (ys[i] >>> i);
        yr <= ys[i] + (xs[i] >>> i);
        zr <= zs[i] - atan_entry(i);
      end else begin
        xr <= xs[i] + (ys[i] >>> i);
        yr <= ys[i] - (xs[i] >>> i);
        zr <= zs[i] + atan_entry(i);
      end
    end
    assign xs[i+1] = xr;
    assign ys[i+1] = yr;
    assign zs[i+1] = zr;
  end

  assign cos_h = xs[TRIG_STAGES];
  assign sin_h = ys[TRIG_STAGES];

  logic unused;
  assign unused = rst ^ in_valid ^ zs[TRIG_STAGES][0];
endmodule
`default_nettype wire

// File: design/e2q_qmul.sv
`default_nettype none
module e2q_qmul (
  input  wire logic           clk,
  input  wire e2q_pkg::quat_t a,
  input  wire e2q_pkg::quat_t b,
  output e2q_pkg::quat_t      r
);
  import e2q_pkg::*;

  localparam int MW = 2 * CW;
  localparam int SW = MW + 2;

  logic signed [MW-1:0] p [16];

  // Sixteen partial products, registered
  always_ff @(posedge clk) begin
    p[0]  <= a.w * b.w;  p[1]  <= a.x * b.x;  p[2]  <= a.y * b.y;  p[3]  <= a.z * b.z;
    p[4]  <= a.w * b.x;  p[5]  <= a.x * b.w;  p[6]  <= a.y * b.z;  p[7]  <= a.z * b.y;
    p[8]  <= a.w * b.y;  p[9]  <= a.x * b.z;  p[10] <= a.y * b.w;  p[11] <= a.z * b.x;
    p[12] <= a.w * b.z;  p[13] <= a.x * b.y;  p[14] <= a.y * b.x;  p[15] <= a.z * b.w;
  end

  logic signed [SW-1:0] sw, sx, sy, sz;
  assign sw = SW'(p[0])  - SW'(p[1])  - SW'(p[2])  - SW'(p[3]);
  assign sx = SW'(p[4])  + SW'(p[5])  + SW'(p[6])  - SW'(p[7]);
  assign sy = SW'(p[8])  - SW'(p[9])  + SW'(p[10]) + SW'(p[11]);
  assign sz = SW'(p[12]) + SW'(p[13]) - SW'(p[14]) + SW'(p[15]);

  // Sum the partial products, drop 30 fraction bits (floor) and register
  always_ff @(posedge clk) begin
    r.w <= CW'(sw >>> 30);
    r.x <= CW'(sx >>> 30);
    r.y <= CW'(sy >>> 30);
    r.z <= CW'(sz >>> 30);
  end
endmodule
`default_nettype wire
